// File: src/dpb_pkg.sv
// ----------------------------------------------------------------------------
// dpb_pkg: shared types and constants for depth pixel back-projection
// Request structs, register map, widths of the offset datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dpb_pkg;

  // Pixel coordinate width
  localparam int COORD_BITS = 12;
  localparam int DEPTH_W    = 16;
  localparam int INV_W      = 24;
  localparam int LABEL_W    = 32;
  localparam int COLOR_W    = 8;
  localparam int OFFSET_W   = 32;

  // Offset datapath widths
  localparam int SCALED_W = COORD_BITS + 4;
  localparam int MAG_W    = (SCALED_W > 16) ? SCALED_W : 16;
  localparam int PD_W     = MAG_W + DEPTH_W;
  localparam int LO_W     = PD_W / 2;
  localparam int HI_W     = PD_W - LO_W;
  localparam int PROD_W   = PD_W + INV_W;
  localparam int SUM_W    = PROD_W + 1;
  localparam int FRAC_W   = 28;
  localparam int Q_W      = SUM_W - FRAC_W;
  localparam int QX_W     = (Q_W > 33) ? Q_W : 33;

  // Pipeline stages
  localparam int PIPE_DEPTH = 5;

  // Register file
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  typedef enum logic [2:0] {
    REG_MIN_DEPTH   = 3'd0,
    REG_MAX_DEPTH   = 3'd1,
    REG_CENTER_X    = 3'd2,
    REG_CENTER_Y    = 3'd3,
    REG_INV_FOCAL_X = 3'd4,
    REG_INV_FOCAL_Y = 3'd5,
    REG_MASK_EN     = 3'd6,
    REG_USE_RGB     = 3'd7
  } reg_idx_e;

  localparam logic [DEPTH_W-1:0] MIN_DEPTH_RST = 16'd70;
  localparam logic [DEPTH_W-1:0] MAX_DEPTH_RST = 16'd6000;

  typedef struct packed {
    logic [15:0]      min_depth_mm;
    logic [15:0]      max_depth_mm;
    logic [15:0]      center_x;
    logic [15:0]      center_y;
    logic [INV_W-1:0] inv_focal_x;
    logic [INV_W-1:0] inv_focal_y;
    logic             mask_en;
    logic             use_rgb;
  } cfg_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] column;
    logic [COORD_BITS-1:0] row;
    logic [DEPTH_W-1:0]    depth_mm;
    logic [LABEL_W-1:0]    mask_label;
    logic [COLOR_W-1:0]    red_in;
    logic [COLOR_W-1:0]    green_in;
    logic [COLOR_W-1:0]    blue_in;
  } in_t;

  typedef struct packed {
    logic [DEPTH_W-1:0]         forward_mm;
    logic signed [OFFSET_W-1:0] lateral_mm;
    logic signed [OFFSET_W-1:0] vertical_mm;
    logic [COLOR_W-1:0]         red_out;
    logic [COLOR_W-1:0]         green_out;
    logic [COLOR_W-1:0]         blue_out;
    logic [LABEL_W-1:0]         label_out;
  } out_t;

  // Fields that ride beside the offset datapath
  typedef struct packed {
    logic [DEPTH_W-1:0] forward_mm;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic [LABEL_W-1:0] label;
  } side_t;

  // Per-stage load strobes
  typedef struct packed {
    logic [PIPE_DEPTH-1:0] load;
  } pipe_ctrl_t;

endpackage

`default_nettype wire

// File: src/dpb_regs.sv
// ----------------------------------------------------------------------------
// dpb_regs: configuration register file
// APB-style write and read of the eight camera and filter registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dpb_regs
  import dpb_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output cfg_t                   cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx   = reg_idx_e'(paddr[4:2]);
  assign wr_en = psel & penable & pwrite;

  // Decode write
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_MIN_DEPTH:   cfg_d.min_depth_mm = pwdata[15:0];
        REG_MAX_DEPTH:   cfg_d.max_depth_mm = pwdata[15:0];
        REG_CENTER_X:    cfg_d.center_x     = pwdata[15:0];
        REG_CENTER_Y:    cfg_d.center_y     = pwdata[15:0];
        REG_INV_FOCAL_X: cfg_d.inv_focal_x  = pwdata[INV_W-1:0];
        REG_INV_FOCAL_Y: cfg_d.inv_focal_y  = pwdata[INV_W-1:0];
        REG_MASK_EN:     cfg_d.mask_en      = pwdata[0];
        REG_USE_RGB:     cfg_d.use_rgb      = pwdata[0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_depth_mm <= MIN_DEPTH_RST;
      cfg_q.max_depth_mm <= MAX_DEPTH_RST;
      cfg_q.center_x     <= '0;
      cfg_q.center_y     <= '0;
      cfg_q.inv_focal_x  <= '0;
      cfg_q.inv_focal_y  <= '0;
      cfg_q.mask_en      <= 1'b1;
      cfg_q.use_rgb      <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read mux
  always_comb begin
    case (idx)
      REG_MIN_DEPTH:   prdata = DATA_W'(cfg_q.min_depth_mm);
      REG_MAX_DEPTH:   prdata = DATA_W'(cfg_q.max_depth_mm);
      REG_CENTER_X:    prdata = DATA_W'(cfg_q.center_x);
      REG_CENTER_Y:    prdata = DATA_W'(cfg_q.center_y);
      REG_INV_FOCAL_X: prdata = DATA_W'(cfg_q.inv_focal_x);
      REG_INV_FOCAL_Y: prdata = DATA_W'(cfg_q.inv_focal_y);
      REG_MASK_EN:     prdata = DATA_W'(cfg_q.mask_en);
      REG_USE_RGB:     prdata = DATA_W'(cfg_q.use_rgb);
      default:         prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: src/dpb_offset.sv
// ----------------------------------------------------------------------------
// dpb_offset: pipelined lateral or vertical offset
// round((coord*16 - center) * depth * inv / 2^28), saturated to 32 bits,
// in five register stages: difference, depth product, split focal product,
// rounding sum, saturate and sign.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dpb_offset
  import dpb_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire pipe_ctrl_t            ctrl_i,
  input  wire logic [COORD_BITS-1:0] coord_i,
  input  wire logic [15:0]           center_i,
  input  wire logic [DEPTH_W-1:0]    depth_i,
  input  wire logic [INV_W-1:0]      inv_i,
  output logic      [OFFSET_W-1:0]   offset_o
);

  localparam logic [SUM_W-1:0]  ROUND   = SUM_W'(1) << (FRAC_W - 1);
  localparam logic [QX_W-1:0]   POS_LIM = QX_W'(64'h7FFF_FFFF);
  localparam logic [QX_W-1:0]   NEG_LIM = QX_W'(64'h8000_0000);

  logic [MAG_W:0]          diff;
  logic [MAG_W-1:0]        mag_q;
  logic [DEPTH_W-1:0]      depth_q;
  logic [PD_W-1:0]         pd_q;
  logic [LO_W+INV_W-1:0]   pl_q;
  logic [HI_W+INV_W-1:0]   ph_q;
  logic [SUM_W-1:0]        sum;
  logic [Q_W-1:0]          q_q;
  logic [QX_W-1:0]         qx;
  logic [QX_W-1:0]         lim;
  logic                    neg0_q;
  logic                    neg1_q;
  logic                    neg2_q;
  logic                    neg3_q;
  logic [OFFSET_W-1:0]     offset_q;

  // Stage 0: signed distance to principal point, split into sign and magnitude
  assign diff = (MAG_W + 1)'({coord_i, 4'b0000}) - (MAG_W + 1)'(center_i);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[0]) begin
      neg0_q  <= diff[MAG_W];
      mag_q   <= diff[MAG_W] ? MAG_W'(-diff) : diff[MAG_W-1:0];
      depth_q <= depth_i;
    end
  end

  // Stage 1: magnitude times depth
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[1]) begin
      neg1_q <= neg0_q;
      pd_q   <= PD_W'(mag_q) * PD_W'(depth_q);
    end
  end

  // Stage 2: focal product as two partial products
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[2]) begin
      neg2_q <= neg1_q;
      pl_q   <= (LO_W + INV_W)'(pd_q[LO_W-1:0]) * (LO_W + INV_W)'(inv_i);
      ph_q   <= (HI_W + INV_W)'(pd_q[PD_W-1:LO_W]) * (HI_W + INV_W)'(inv_i);
    end
  end

  // Stage 3: combine partials, round half away from zero on the magnitude
  assign sum = SUM_W'(pl_q) + (SUM_W'(ph_q) << LO_W) + ROUND;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[3]) begin
      neg3_q <= neg2_q;
      q_q    <= sum[SUM_W-1:FRAC_W];
    end
  end

  // Stage 4: clamp to the signed range and apply sign
  assign qx = QX_W'(q_q);

  always_comb begin
    if (neg3_q) begin
      lim = (qx > NEG_LIM) ? NEG_LIM : qx;
    end else begin
      lim = (qx > POS_LIM) ? POS_LIM : qx;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[4]) begin
      offset_q <= neg3_q ? (OFFSET_W'(0) - lim[OFFSET_W-1:0]) : lim[OFFSET_W-1:0];
    end
  end

  assign offset_o = offset_q;

endmodule

`default_nettype wire

// File: src/depth_pixel_backprojection.sv
// ----------------------------------------------------------------------------
// depth_pixel_backprojection: pinhole back-projection of depth pixels
// Filters pixels by depth window and label, then forms forward, lateral and
// vertical position in millimetres with optional color.
//
//   channel  direction  handshake                   payload
//   in       sink       in_valid_i / in_stall_o     in_req_i  (in_t)
//   out      source     out_valid_o / out_stall_i   out_req_o (out_t)
//   config   sink       APB psel/penable/pwrite     paddr, pwdata, prdata
//
// One pixel per cycle sustained while the output is not stalled; a kept pixel
// passes through five register stages, the first loaded at its accepting
// edge, a depth set by the offset multiply chain. Rejected pixels are
// dropped at entry and leave a bubble. in_stall_o rises only when every
// stage holds a point and the output is stalled; bubbles are squeezed out.
// Reset clears all stage valid bits and loads register defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module depth_pixel_backprojection
  import dpb_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire in_t               in_req_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output out_t                   out_req_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready
);

  cfg_t                  cfg;
  pipe_ctrl_t            ctrl;
  logic [PIPE_DEPTH-1:0] valid_q, valid_d;
  logic [PIPE_DEPTH-1:0] ready;
  logic [PIPE_DEPTH-1:0] vin;
  logic [LABEL_W-1:0]    label_eff;
  logic                  keep;
  side_t                 side_in;
  side_t                 side_q [PIPE_DEPTH];
  logic [OFFSET_W-1:0]   lateral, vertical;

  assign pready = 1'b1;

  dpb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg)
  );

  // Qualify the pixel against the depth window and label
  assign label_eff = cfg.mask_en ? in_req_i.mask_label : LABEL_W'(1);
  assign keep = (in_req_i.depth_mm > cfg.min_depth_mm) &&
                (in_req_i.depth_mm < cfg.max_depth_mm) &&
                (label_eff != '0);

  always_comb begin
    side_in.forward_mm = in_req_i.depth_mm;
    side_in.red        = cfg.use_rgb ? in_req_i.red_in   : '0;
    side_in.green      = cfg.use_rgb ? in_req_i.green_in : '0;
    side_in.blue       = cfg.use_rgb ? in_req_i.blue_in  : '0;
    side_in.label      = label_eff;
  end

  // Stage handshake: a stage takes new data when empty or when it drains
  always_comb begin
    ready[PIPE_DEPTH-1] = !valid_q[PIPE_DEPTH-1] || !out_stall_i;
    for (int k = PIPE_DEPTH - 2; k >= 0; k--) begin
      ready[k] = !valid_q[k] || ready[k+1];
    end
    vin[0] = in_valid_i && keep;
    for (int k = 1; k < PIPE_DEPTH; k++) begin
      vin[k] = valid_q[k-1];
    end
    for (int k = 0; k < PIPE_DEPTH; k++) begin
      valid_d[k]   = ready[k] ? vin[k] : valid_q[k];
      ctrl.load[k] = ready[k] && vin[k];
    end
  end

  assign in_stall_o = !ready[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Carry depth, color and label beside the offset datapath
  always_ff @(posedge clk_i) begin
    if (ctrl.load[0]) begin
      side_q[0] <= side_in;
    end
    for (int k = 1; k < PIPE_DEPTH; k++) begin
      if (ctrl.load[k]) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  dpb_offset u_lateral (
    .clk_i    (clk_i),
    .ctrl_i   (ctrl),
    .coord_i  (in_req_i.column),
    .center_i (cfg.center_x),
    .depth_i  (in_req_i.depth_mm),
    .inv_i    (cfg.inv_focal_x),
    .offset_o (lateral)
  );

  dpb_offset u_vertical (
    .clk_i    (clk_i),
    .ctrl_i   (ctrl),
    .coord_i  (in_req_i.row),
    .center_i (cfg.center_y),
    .depth_i  (in_req_i.depth_mm),
    .inv_i    (cfg.inv_focal_y),
    .offset_o (vertical)
  );

  // Assemble the result request
  always_comb begin
    out_req_o.forward_mm  = side_q[PIPE_DEPTH-1].forward_mm;
    out_req_o.lateral_mm  = lateral;
    out_req_o.vertical_mm = vertical;
    out_req_o.red_out     = side_q[PIPE_DEPTH-1].red;
    out_req_o.green_out   = side_q[PIPE_DEPTH-1].green;
    out_req_o.blue_out    = side_q[PIPE_DEPTH-1].blue;
    out_req_o.label_out   = side_q[PIPE_DEPTH-1].label;
  end

  assign out_valid_o = valid_q[PIPE_DEPTH-1];

endmodule

`default_nettype wire

// File: src/dpb_checker.sv
// ----------------------------------------------------------------------------
// dpb_checker: port-level checks for depth pixel back-projection
// Watches the request channels of the top level over time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dpb_checker
  import dpb_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_stall_o,
  input wire logic out_valid_o,
  input wire logic out_stall_i,
  input wire out_t out_req_o
);

  // Hold a stalled result request
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_req_o))
    else $error("stalled result request changed or dropped");

  // Input backs up only behind a full, stalled output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

  // A kept point has positive depth and a nonzero label
  a_point_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_req_o.forward_mm != '0) && (out_req_o.label_out != '0))
    else $error("result with zero depth or zero label");

  // Pipeline comes out of reset empty
  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result valid right after reset");

endmodule

bind depth_pixel_backprojection dpb_checker u_dpb_checker (.*);

`default_nettype wire
